FILE: src/isopava_pkg.sv
// ----------------------------------------------------------------------------
// isopava_pkg
// Shared types and codes for the isotonic regression block.
// ----------------------------------------------------------------------------
package isopava_pkg;

    // Operation codes carried by the opcode field.
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Fixed field widths of the ports.
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned MEAN_W   = 24;
    localparam int unsigned FRAC_W   = 8;

endpackage

FILE: src/isopava_ram.sv
// ----------------------------------------------------------------------------
// isopava_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module isopava_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, and read through an output register.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: src/isotonic_regression_pava.sv
// ----------------------------------------------------------------------------
// isotonic_regression_pava
// Pool-adjacent-violators isotonic fit kept as a block stack in one RAM.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_in_valid / o_in_stall) carries one operation
// per transfer: push a sample, read one block, or clear the stack. Every
// operation gives exactly one result on the output channel (o_out_valid /
// i_out_stall) with a status, the block count and one block's start,
// length and Q8 mean.
// The block works on one operation at a time. A push writes the new block
// and then checks the block below it, again after every merge; each check
// takes a RAM read, a registered cross-multiply and a compare (S_CHK,
// S_MUL, S_CMP). Any result that reports a block then runs a radix-2
// divider, one quotient bit per cycle over the sample width plus the clog2
// of the depth plus nine bits (35 bits by default), followed by a fix-up
// step. Clear, unused opcodes and out-of-range reads skip the divider. The
// next operation can be accepted in the cycle after the result is registered.
// A finished result waits in the output register while the next operation
// is accepted; the block holds its last step until the receiver takes it.
// Reset empties the stack at once; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module isotonic_regression_pava #(
    parameter int unsigned MAX_SAMPLES = 1024,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic signed [15:0] i_sample,
    input  logic [9:0]  i_block_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [10:0] o_block_count,
    output logic [9:0]  o_block_start,
    output logic [10:0] o_block_length,
    output logic signed [23:0] o_fit_mean
);

    localparam int unsigned AW   = $clog2(MAX_SAMPLES);
    localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned SW   = SAMPLE_BITS + AW + 1;
    localparam int unsigned EW   = SW + AW + CW;
    localparam int unsigned PW   = SW + CW + 1;
    localparam int unsigned DW   = SW + isopava_pkg::FRAC_W;
    localparam int unsigned NW   = $clog2(DW + 1);
    localparam int unsigned MW   = (DW + 1 > 25) ? DW + 1 : 25;
    localparam logic signed [MW-1:0] MEAN_HI = MW'(8388607);
    localparam logic signed [MW-1:0] MEAN_LO = -MW'(8388608);

    typedef enum logic [2:0] {
        S_IDLE, S_CHK, S_MUL, S_CMP, S_LOAD, S_DIV, S_FIX, S_DONE
    } t_state;

    t_state                   r_state;
    logic [CW-1:0]            r_bh;
    logic [CW-1:0]            r_sh;
    logic signed [SW-1:0]     r_top_sum;
    logic [AW-1:0]            r_top_start;
    logic [CW-1:0]            r_top_len;
    logic signed [SW-1:0]     r_bel_sum;
    logic [AW-1:0]            r_bel_start;
    logic [CW-1:0]            r_bel_len;
    logic signed [PW-1:0]     r_lhs;
    logic signed [PW-1:0]     r_rhs;
    logic [CW-1:0]            r_dvs;
    logic [CW-1:0]            r_rem;
    logic [DW-1:0]            r_quo;
    logic [NW-1:0]            r_cnt;
    logic                     r_neg;
    isopava_pkg::t_status     r_res_status;
    logic [AW-1:0]            r_res_start;
    logic [CW-1:0]            r_res_len;
    logic signed [23:0]       r_res_mean;

    logic signed [SW-1:0]     w_samp;
    logic                     w_accept;
    logic                     w_full;
    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [EW-1:0]            w_wdata;
    logic [AW-1:0]            w_raddr;
    logic [EW-1:0]            w_rdata;
    logic signed [SW-1:0]     w_rd_sum;
    logic [AW-1:0]            w_rd_start;
    logic [CW-1:0]            w_rd_len;
    logic                     w_merge;
    logic signed [SW-1:0]     w_msum;
    logic [CW-1:0]            w_mlen;
    logic [CW:0]              w_rem_sh;
    logic                     w_ge;
    logic signed [DW:0]       w_q;
    logic signed [MW-1:0]     w_qw;
    logic                     w_out_free;
    logic [AW-1:0]            w_below;

    // Sign-extend low SAMPLE_BITS bits; zero-extend i_sample if wider than 16.
    generate
        if (SAMPLE_BITS <= 16) begin : g_narrow
            assign w_samp = SW'($signed(i_sample[SAMPLE_BITS-1:0]));
        end else begin : g_wide
            assign w_samp = SW'($signed({1'b0, i_sample}));
        end
    endgenerate

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_full     = (r_sh >= CW'(MAX_SAMPLES));
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_below    = AW'(r_bh - CW'(2));

    // Unpack the RAM read word.
    assign w_rd_sum   = w_rdata[EW-1 -: SW];
    assign w_rd_start = w_rdata[CW +: AW];
    assign w_rd_len   = w_rdata[CW-1:0];

    // Merge decision and the pooled block.
    assign w_merge = (r_lhs > r_rhs);
    assign w_msum  = r_bel_sum + r_top_sum;
    assign w_mlen  = r_bel_len + r_top_len;

    // RAM port control: new block on push, pooled block on merge.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = AW'(r_bh);
        w_wdata = {w_samp, AW'(r_sh), CW'(1)};
        w_raddr = AW'(i_block_index);
        if (w_accept && (i_opcode == isopava_pkg::OP_PUSH) && !w_full) begin
            w_we = 1'b1;
        end
        if ((r_state == S_CMP) && w_merge) begin
            w_we    = 1'b1;
            w_waddr = w_below;
            w_wdata = {w_msum, r_bel_start, w_mlen};
        end
        if (r_state == S_CHK) begin
            w_raddr = w_below;
        end
    end

    // Divider step and signed floor fix-up.
    assign w_rem_sh = {r_rem, r_quo[DW-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});
    always_comb begin
        w_q = $signed({1'b0, r_quo});
        if (r_neg) begin
            w_q = -(w_q + (DW+1)'(r_rem != '0));
        end
        w_qw = MW'(w_q);
    end

    isopava_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_SAMPLES)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Sequencer, stack pointers, divider and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bh        <= '0;
            r_sh        <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_start <= '0;
                        r_res_len   <= '0;
                        r_res_mean  <= '0;
                        unique case (i_opcode)
                            isopava_pkg::OP_PUSH: begin
                                if (w_full) begin
                                    r_res_status <= isopava_pkg::ST_FULL;
                                    if (r_bh != '0) begin
                                        r_dvs   <= r_top_len;
                                        r_state <= S_LOAD;
                                    end else begin
                                        r_state <= S_DONE;
                                    end
                                end else begin
                                    r_res_status <= isopava_pkg::ST_OK;
                                    r_top_sum    <= w_samp;
                                    r_top_start  <= AW'(r_sh);
                                    r_top_len    <= CW'(1);
                                    r_bh         <= r_bh + CW'(1);
                                    r_sh         <= r_sh + CW'(1);
                                    r_state      <= S_CHK;
                                end
                            end
                            isopava_pkg::OP_READ: begin
                                if (CW'(i_block_index) >= r_bh
                                    || 32'(i_block_index) >= MAX_SAMPLES) begin
                                    r_res_status <= isopava_pkg::ST_RANGE;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res_status <= isopava_pkg::ST_OK;
                                    r_state      <= S_LOAD;
                                    r_dvs        <= '0;
                                end
                            end
                            isopava_pkg::OP_CLEAR: begin
                                r_res_status <= isopava_pkg::ST_OK;
                                r_bh         <= '0;
                                r_sh         <= '0;
                                r_state      <= S_DONE;
                            end
                            default: begin
                                r_res_status <= isopava_pkg::ST_OK;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_CHK: begin
                    if (r_bh >= CW'(2)) begin
                        r_state <= S_MUL;
                    end else begin
                        r_dvs   <= r_top_len;
                        r_state <= S_LOAD;
                    end
                end
                S_MUL: begin
                    r_bel_sum   <= w_rd_sum;
                    r_bel_start <= w_rd_start;
                    r_bel_len   <= w_rd_len;
                    r_lhs <= PW'(w_rd_sum * $signed({1'b0, r_top_len}));
                    r_rhs <= PW'(r_top_sum * $signed({1'b0, w_rd_len}));
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_merge) begin
                        r_top_sum   <= w_msum;
                        r_top_start <= r_bel_start;
                        r_top_len   <= w_mlen;
                        r_bh        <= r_bh - CW'(1);
                        r_state     <= S_CHK;
                    end else begin
                        r_dvs   <= r_top_len;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    // A zero divisor marks a read: take the block from the RAM.
                    if (r_dvs == '0) begin
                        r_res_start <= w_rd_start;
                        r_res_len   <= w_rd_len;
                        r_dvs       <= w_rd_len;
                        r_neg       <= w_rd_sum[SW-1];
                        r_quo       <= {(w_rd_sum[SW-1] ? SW'(-w_rd_sum) : SW'(w_rd_sum)),
                                        isopava_pkg::FRAC_W'(0)};
                    end else begin
                        r_res_start <= r_top_start;
                        r_res_len   <= r_top_len;
                        r_neg       <= r_top_sum[SW-1];
                        r_quo       <= {(r_top_sum[SW-1] ? SW'(-r_top_sum) : SW'(r_top_sum)),
                                        isopava_pkg::FRAC_W'(0)};
                    end
                    r_rem   <= '0;
                    r_cnt   <= NW'(DW);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_ge ? CW'(w_rem_sh - {1'b0, r_dvs}) : CW'(w_rem_sh);
                    r_quo <= {r_quo[DW-2:0], w_ge};
                    r_cnt <= r_cnt - NW'(1);
                    if (r_cnt == NW'(1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    if (w_qw > MEAN_HI) begin
                        r_res_mean <= 24'sh7FFFFF;
                    end else if (w_qw < MEAN_LO) begin
                        r_res_mean <= -24'sh800000;
                    end else begin
                        r_res_mean <= 24'(w_qw);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        o_out_valid    <= 1'b1;
                        o_status       <= r_res_status;
                        o_block_count  <= 11'(r_bh);
                        o_block_start  <= 10'(r_res_start);
                        o_block_length <= 11'(r_res_len);
                        o_fit_mean     <= r_res_mean;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
